### hw/rtl/i2c_bit_level_master_top_macros.svh
// ----------------------------------------------------------------------------
// I2C bit-level master: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define I2CBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define I2CBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// I2C bit-level master: package
// Request and result types, operation and phase codes, register defaults.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  // Operation codes; codes above OP_READ behave as a tick.
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_WAITACK = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SHORT_TICKS = 2'd0,
    CFG_LONG_TICKS  = 2'd1,
    CFG_ACK_TIMEOUT = 2'd2
  } cfg_idx_t;

  localparam logic [7:0]  SHORT_TICKS_RST = 8'd2;
  localparam logic [7:0]  LONG_TICKS_RST  = 8'd5;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'h1000;

  // Sequencer phases.
  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
    PH_WR_FIRST, PH_WR_HI, PH_WR_LO, PH_WR_TAIL,
    PH_WA_HI, PH_WA_POLL,
    PH_RD_HI, PH_RD_SMP, PH_RD_TAIL,
    PH_AK_SET, PH_AK_HI, PH_AK_END
  } phase_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       rejected;
  } out_item_t;

endpackage

### hw/rtl/i2c_bit_level_master_top.sv
// ----------------------------------------------------------------------------
// I2C bit-level master: top level
// Drives SCL/SDA levels from counted delay ticks; commands start sequences,
// ticks advance them, and every request returns the pin levels and status.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        request    in_valid/in_stall    in_data (in_item_t)
// out       result     out_valid/out_stall  out_data (out_item_t)
// cfg       write      cfg_we               cfg_index, cfg_data
//
// One request per clock while in_stall is low; its result, set by the
// single pass through the sequencer logic, is registered in the buffer.
// Bus timing follows the number of tick requests, not the clock.
// Reset (rst, synchronous) restores the default registers and an idle bus.
// A two-entry result buffer absorbs output stalls; in_stall is high only
// while both entries are full.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_top
  import i2cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic      in_fire;
  out_item_t core_result;

  assign in_fire = in_valid && !in_stall;

  // Sequencer and configuration.
  i2cbm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_fire (in_fire),
    .item      (in_data),
    .result    (core_result)
  );

  // Result register and skid entry.
  i2cbm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .load_data (core_result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/i2cbm_core.sv
// ----------------------------------------------------------------------------
// I2C bit-level master: sequencer core
// Holds the configuration and the bus sequencer state, and works out the
// result of each accepted request in a single pass.
// ----------------------------------------------------------------------------
module i2cbm_core
  import i2cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_fire,
  input  in_item_t    item,
  output out_item_t   result
);

  // Configuration registers.
  logic [7:0]  short_ticks;
  logic [7:0]  long_ticks;
  logic [15:0] ack_timeout;

  // Sequencer state.
  phase_t      phase, phase_next;
  logic [2:0]  cur_cmd, cur_cmd_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  delay_left, delay_left_next;
  logic [15:0] ack_wait_left, ack_wait_left_next;
  logic        ack_choice, ack_choice_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic        drive_reg, drive_reg_next;
  logic [7:0]  last_read, last_read_next;
  logic        last_ack, last_ack_next;
  logic        finished;
  logic        rej;

  logic [7:0]  short_units;
  logic [7:0]  long_units;
  logic [3:0]  bit_inc;
  logic [15:0] ack_dec;

  // A wait of zero units lasts one tick.
  assign short_units = (short_ticks == 8'd0) ? 8'd1 : short_ticks;
  assign long_units  = (long_ticks == 8'd0) ? 8'd1 : long_ticks;
  assign bit_inc     = bit_index + 4'd1;
  assign ack_dec     = ack_wait_left - 16'd1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= SHORT_TICKS_RST;
      long_ticks  <= LONG_TICKS_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_TICKS: short_ticks <= cfg_data[7:0];
        CFG_LONG_TICKS:  long_ticks  <= cfg_data[7:0];
        CFG_ACK_TIMEOUT: ack_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state and result for the request at the input.
  always_comb begin
    phase_next         = phase;
    cur_cmd_next       = cur_cmd;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    delay_left_next    = delay_left;
    ack_wait_left_next = ack_wait_left;
    ack_choice_next    = ack_choice;
    scl_reg_next       = scl_reg;
    sda_reg_next       = sda_reg;
    drive_reg_next     = drive_reg;
    last_read_next     = last_read;
    last_ack_next      = last_ack;
    finished           = 1'b0;
    rej                = 1'b0;

    if (item.operation inside {[OP_START:OP_READ]}) begin
      if (phase != PH_IDLE) begin
        // A command while busy is dropped and time does not advance.
        rej = 1'b1;
      end else begin
        cur_cmd_next = item.operation;
        case (item.operation)
          OP_START: begin
            drive_reg_next  = 1'b1;
            sda_reg_next    = 1'b1;
            scl_reg_next    = 1'b1;
            delay_left_next = long_units;
            phase_next      = PH_ST_A;
          end
          OP_STOP: begin
            drive_reg_next  = 1'b1;
            scl_reg_next    = 1'b0;
            sda_reg_next    = 1'b0;
            delay_left_next = long_units;
            phase_next      = PH_SP_A;
          end
          OP_WRITE: begin
            drive_reg_next  = 1'b1;
            scl_reg_next    = 1'b0;
            shift_byte_next = item.write_byte;
            bit_index_next  = 4'd0;
            delay_left_next = short_units;
            phase_next      = PH_WR_FIRST;
          end
          OP_WAITACK: begin
            drive_reg_next     = 1'b0;
            sda_reg_next       = 1'b1;
            ack_wait_left_next = (ack_timeout == 16'd0) ? 16'd1 : ack_timeout;
            delay_left_next    = short_units;
            phase_next         = PH_WA_HI;
          end
          default: begin
            drive_reg_next  = 1'b0;
            sda_reg_next    = 1'b1;
            scl_reg_next    = 1'b0;
            shift_byte_next = 8'd0;
            bit_index_next  = 4'd0;
            ack_choice_next = item.send_ack;
            delay_left_next = short_units;
            phase_next      = PH_RD_HI;
          end
        endcase
      end
    end else if (phase != PH_IDLE) begin
      if (delay_left > 8'd1) begin
        delay_left_next = delay_left - 8'd1;
      end else begin
        // The wait ends on this tick; perform the actions that follow it.
        delay_left_next = 8'd0;
        case (phase)
          PH_ST_A: begin
            sda_reg_next    = 1'b0;
            delay_left_next = long_units;
            phase_next      = PH_ST_B;
          end
          PH_ST_B: begin
            scl_reg_next = 1'b0;
            phase_next   = PH_IDLE;
            finished     = 1'b1;
          end
          PH_SP_A: begin
            scl_reg_next    = 1'b1;
            sda_reg_next    = 1'b1;
            delay_left_next = long_units;
            phase_next      = PH_SP_B;
          end
          PH_SP_B: begin
            if (cur_cmd == OP_WAITACK) begin
              last_ack_next = 1'b0;
            end
            phase_next = PH_IDLE;
            finished   = 1'b1;
          end
          PH_WR_FIRST: begin
            sda_reg_next    = shift_byte[7];
            shift_byte_next = {shift_byte[6:0], 1'b0};
            delay_left_next = short_units;
            phase_next      = PH_WR_HI;
          end
          PH_WR_HI: begin
            scl_reg_next    = 1'b1;
            delay_left_next = short_units;
            phase_next      = PH_WR_LO;
          end
          PH_WR_LO: begin
            scl_reg_next    = 1'b0;
            delay_left_next = short_units;
            phase_next      = PH_WR_TAIL;
          end
          PH_WR_TAIL: begin
            bit_index_next = bit_inc;
            if (bit_inc >= 4'(BITS_PER_BYTE)) begin
              phase_next = PH_IDLE;
              finished   = 1'b1;
            end else begin
              sda_reg_next    = shift_byte[7];
              shift_byte_next = {shift_byte[6:0], 1'b0};
              delay_left_next = short_units;
              phase_next      = PH_WR_HI;
            end
          end
          PH_WA_HI: begin
            scl_reg_next    = 1'b1;
            delay_left_next = short_units;
            phase_next      = PH_WA_POLL;
          end
          PH_WA_POLL: begin
            if (!item.sda_sample) begin
              scl_reg_next  = 1'b0;
              last_ack_next = 1'b1;
              phase_next    = PH_IDLE;
              finished      = 1'b1;
            end else begin
              ack_wait_left_next = ack_dec;
              if (ack_dec == 16'd0) begin
                // Timed out: run a stop sequence.
                drive_reg_next  = 1'b1;
                scl_reg_next    = 1'b0;
                sda_reg_next    = 1'b0;
                delay_left_next = long_units;
                phase_next      = PH_SP_A;
              end else begin
                delay_left_next = 8'd1;
              end
            end
          end
          PH_RD_HI: begin
            scl_reg_next    = 1'b1;
            delay_left_next = short_units;
            phase_next      = PH_RD_SMP;
          end
          PH_RD_SMP: begin
            shift_byte_next = {shift_byte[6:0], item.sda_sample};
            delay_left_next = short_units;
            phase_next      = PH_RD_TAIL;
          end
          PH_RD_TAIL: begin
            bit_index_next  = bit_inc;
            scl_reg_next    = 1'b0;
            delay_left_next = short_units;
            if (bit_inc < 4'(BITS_PER_BYTE)) begin
              phase_next = PH_RD_HI;
            end else begin
              last_read_next = shift_byte;
              drive_reg_next = 1'b1;
              phase_next     = PH_AK_SET;
            end
          end
          PH_AK_SET: begin
            sda_reg_next    = !ack_choice;
            delay_left_next = short_units;
            phase_next      = PH_AK_HI;
          end
          PH_AK_HI: begin
            scl_reg_next    = 1'b1;
            delay_left_next = long_units;
            phase_next      = PH_AK_END;
          end
          PH_AK_END: begin
            scl_reg_next = 1'b0;
            phase_next   = PH_IDLE;
            finished     = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
            finished   = 1'b1;
          end
        endcase
      end
    end

    result.scl_level = scl_reg_next;
    result.sda_level = sda_reg_next;
    result.sda_drive = drive_reg_next;
    result.busy_res  = (phase_next != PH_IDLE);
    result.done_res  = finished;
    result.read_byte = last_read_next;
    result.ack_seen  = last_ack_next;
    result.rejected  = rej;
  end

  // State update on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cur_cmd       <= 3'd0;
      bit_index     <= 4'd0;
      shift_byte    <= 8'd0;
      delay_left    <= 8'd0;
      ack_wait_left <= 16'd0;
      ack_choice    <= 1'b0;
      scl_reg       <= 1'b1;
      sda_reg       <= 1'b1;
      drive_reg     <= 1'b1;
      last_read     <= 8'd0;
      last_ack      <= 1'b0;
    end else if (item_fire) begin
      phase         <= phase_next;
      cur_cmd       <= cur_cmd_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      delay_left    <= delay_left_next;
      ack_wait_left <= ack_wait_left_next;
      ack_choice    <= ack_choice_next;
      scl_reg       <= scl_reg_next;
      sda_reg       <= sda_reg_next;
      drive_reg     <= drive_reg_next;
      last_read     <= last_read_next;
      last_ack      <= last_ack_next;
    end
  end

endmodule

### hw/rtl/i2cbm_out_buf.sv
// ----------------------------------------------------------------------------
// I2C bit-level master: result buffer
// Output register with a skid entry, so a request is taken while a result
// is still waiting downstream.
// ----------------------------------------------------------------------------
module i2cbm_out_buf
  import i2cbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t load_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      skid_valid;
  out_item_t skid_data;
  logic      out_take;

  assign out_take = out_valid && !out_stall;
  assign full     = skid_valid;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (load) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (load) begin
      if (out_valid && !out_take) begin
        skid_data <= load_data;
      end else begin
        out_data <= load_data;
      end
    end
  end

endmodule

### hw/rtl/i2cbm_checker.sv
// ----------------------------------------------------------------------------
// I2C bit-level master: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_bit_level_master_top_macros.svh"

module i2cbm_checker
  import i2cbm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_data
);

  // A stalled result stays put.
  `I2CBM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // Reset empties the result buffer.
  `I2CBM_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result pending after reset")

  // Requests are refused only when a result is already waiting.
  `I2CBM_ASSERT(a_stall_full, in_stall |-> out_valid, "input stalled with empty result register")

  // A finished sequence leaves the bus idle and is never a refusal.
  `I2CBM_ASSERT(a_done_idle, out_valid && out_data.done_res |-> !out_data.busy_res && !out_data.rejected, "done result marked busy or rejected")

  // A refused command only happens while a sequence runs.
  `I2CBM_ASSERT(a_rej_busy, out_valid && out_data.rejected |-> out_data.busy_res, "rejected command on an idle bus")

endmodule

bind i2c_bit_level_master_top i2cbm_checker u_checker (.*);

### tb/sv/tb_i2c_bit_level_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master: self-checking testbench
// Sends start, stop, write, wait-ack and read requests followed by tick
// requests. A cycle-free model of the sequencer predicts the pin levels and
// status for every accepted request, and each returned result is compared
// with the oldest prediction. Directed tests cover reset values, busy
// rejection, register extremes and ack timeouts. Random transactions then
// run under several timing settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_i2c_bit_level_master_top;
  import i2cbm_pkg::*;

  // Spare operation codes that the block treats as a tick.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // How SDA is driven on tick requests outside the ack poll.
  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RANDOM = 2;

  localparam int NEVER_ACK      = 32'h7fff_ffff;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  i2c_bit_level_master_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Sequencer model state.
  phase_t      bus_phase;
  logic [2:0]  cur_cmd;
  logic [3:0]  bit_idx;
  logic [7:0]  shift_q;
  logic [7:0]  delay_cnt;
  logic [15:0] ack_left;
  logic        ack_sel;
  logic        scl_q, sda_q, drive_q;
  logic [7:0]  last_rd;
  logic        last_ack;
  logic        seq_done;
  logic [7:0]  short_ticks_q, long_ticks_q;
  logic [15:0] ack_timeout_q;

  out_item_t   predicted_pins[$];
  out_item_t   want;
  int          requests_sent = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          noise_pct = 0;

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------

  function automatic void reset_predictor();
    bus_phase = PH_IDLE;
    cur_cmd = OP_TICK;
    bit_idx = '0;
    shift_q = '0;
    delay_cnt = '0;
    ack_left = '0;
    ack_sel = 1'b0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    drive_q = 1'b1;
    last_rd = '0;
    last_ack = 1'b0;
    seq_done = 1'b0;
    short_ticks_q = SHORT_TICKS_RST;
    long_ticks_q = LONG_TICKS_RST;
    ack_timeout_q = ACK_TIMEOUT_RST;
  endfunction

  // A wait of zero units still lasts one tick.
  function automatic void arm_wait(input logic [7:0] units, input phase_t nxt);
    delay_cnt = (units != 8'd0) ? units : 8'd1;
    bus_phase = nxt;
  endfunction

  function automatic void end_sequence();
    bus_phase = PH_IDLE;
    delay_cnt = '0;
    seq_done = 1'b1;
  endfunction

  function automatic void begin_stop_cond();
    drive_q = 1'b1;
    scl_q = 1'b0;
    sda_q = 1'b0;
    arm_wait(long_ticks_q, PH_SP_A);
  endfunction

  function automatic void shift_out_bit();
    sda_q = shift_q[7];
    shift_q = shift_q << 1;
    arm_wait(short_ticks_q, PH_WR_HI);
  endfunction

  // Applies one request to the model and returns the pin levels and status.
  function automatic out_item_t predict_pins(input in_item_t req);
    out_item_t res;
    logic      rej;
    rej = 1'b0;
    seq_done = 1'b0;
    if (req.operation >= OP_START && req.operation <= OP_READ) begin
      // A command while a sequence runs is dropped without advancing timing.
      if (bus_phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        cur_cmd = req.operation;
        case (req.operation)
          OP_START: begin
            drive_q = 1'b1;
            sda_q = 1'b1;
            scl_q = 1'b1;
            arm_wait(long_ticks_q, PH_ST_A);
          end
          OP_STOP: begin
            begin_stop_cond();
          end
          OP_WRITE: begin
            drive_q = 1'b1;
            scl_q = 1'b0;
            shift_q = req.write_byte;
            bit_idx = '0;
            arm_wait(short_ticks_q, PH_WR_FIRST);
          end
          OP_WAITACK: begin
            drive_q = 1'b0;
            sda_q = 1'b1;
            ack_left = (ack_timeout_q != 16'd0) ? ack_timeout_q : 16'd1;
            arm_wait(short_ticks_q, PH_WA_HI);
          end
          default: begin
            drive_q = 1'b0;
            sda_q = 1'b1;
            scl_q = 1'b0;
            shift_q = '0;
            bit_idx = '0;
            ack_sel = req.send_ack;
            arm_wait(short_ticks_q, PH_RD_HI);
          end
        endcase
      end
    end else if (bus_phase != PH_IDLE) begin
      // Tick: count down, and on the last unit do the actions after the wait.
      if (delay_cnt > 8'd1) begin
        delay_cnt = delay_cnt - 8'd1;
      end else begin
        delay_cnt = '0;
        case (bus_phase)
          PH_ST_A: begin
            sda_q = 1'b0;
            arm_wait(long_ticks_q, PH_ST_B);
          end
          PH_ST_B: begin
            scl_q = 1'b0;
            end_sequence();
          end
          PH_SP_A: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            arm_wait(long_ticks_q, PH_SP_B);
          end
          PH_SP_B: begin
            // A stop that ends an ack timeout reports no ack.
            if (cur_cmd == OP_WAITACK) last_ack = 1'b0;
            end_sequence();
          end
          PH_WR_FIRST: begin
            shift_out_bit();
          end
          PH_WR_HI: begin
            scl_q = 1'b1;
            arm_wait(short_ticks_q, PH_WR_LO);
          end
          PH_WR_LO: begin
            scl_q = 1'b0;
            arm_wait(short_ticks_q, PH_WR_TAIL);
          end
          PH_WR_TAIL: begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= BITS_PER_BYTE) end_sequence();
            else shift_out_bit();
          end
          PH_WA_HI: begin
            scl_q = 1'b1;
            arm_wait(short_ticks_q, PH_WA_POLL);
          end
          PH_WA_POLL: begin
            if (!req.sda_sample) begin
              scl_q = 1'b0;
              last_ack = 1'b1;
              end_sequence();
            end else begin
              ack_left = ack_left - 16'd1;
              if (ack_left == 16'd0) begin_stop_cond();
              else arm_wait(8'd1, PH_WA_POLL);
            end
          end
          PH_RD_HI: begin
            scl_q = 1'b1;
            arm_wait(short_ticks_q, PH_RD_SMP);
          end
          PH_RD_SMP: begin
            shift_q = {shift_q[6:0], req.sda_sample};
            arm_wait(short_ticks_q, PH_RD_TAIL);
          end
          PH_RD_TAIL: begin
            bit_idx = bit_idx + 4'd1;
            scl_q = 1'b0;
            if (bit_idx < BITS_PER_BYTE) begin
              arm_wait(short_ticks_q, PH_RD_HI);
            end else begin
              last_rd = shift_q;
              drive_q = 1'b1;
              arm_wait(short_ticks_q, PH_AK_SET);
            end
          end
          PH_AK_SET: begin
            sda_q = ~ack_sel;
            arm_wait(short_ticks_q, PH_AK_HI);
          end
          PH_AK_HI: begin
            scl_q = 1'b1;
            arm_wait(long_ticks_q, PH_AK_END);
          end
          PH_AK_END: begin
            // The ack clock pulse ends with SCL low.
            scl_q = 1'b0;
            end_sequence();
          end
          default: begin
            end_sequence();
          end
        endcase
      end
    end
    res.scl_level = scl_q;
    res.sda_level = sda_q;
    res.sda_drive = drive_q;
    res.busy_res = (bus_phase != PH_IDLE);
    res.done_res = seq_done;
    res.read_byte = last_rd;
    res.ack_seen = last_ack;
    res.rejected = rej;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking, receiver stalls and watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_pins.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result %h arrived with no request pending", out_data);
      end else begin
        want = predicted_pins.pop_front();
        if (out_data.scl_level !== want.scl_level || out_data.sda_level !== want.sda_level ||
            out_data.sda_drive !== want.sda_drive || out_data.busy_res !== want.busy_res ||
            out_data.done_res !== want.done_res || out_data.read_byte !== want.read_byte ||
            out_data.ack_seen !== want.ack_seen || out_data.rejected !== want.rejected) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"ERROR: exp/got scl %b/%b sda %b/%b drive %b/%b busy %b/%b ",
                      "done %b/%b read %h/%h ack %b/%b rejected %b/%b"},
                     want.scl_level, out_data.scl_level, want.sda_level, out_data.sda_level,
                     want.sda_drive, out_data.sda_drive, want.busy_res, out_data.busy_res,
                     want.done_res, out_data.done_res, want.read_byte, out_data.read_byte,
                     want.ack_seen, out_data.ack_seen, want.rejected, out_data.rejected);
        end
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("i2c_bit_level_master_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------

  // Sends one request and records its predicted result once it is accepted.
  task automatic send_request(input logic [2:0] op, input logic [7:0] data,
                              input logic ack, input logic sda);
    in_item_t req;
    req.operation = op;
    req.write_byte = data;
    req.send_ack = ack;
    req.sda_sample = sda;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_pins.push_back(predict_pins(req));
    requests_sent++;
  endtask

  // Tick request; now and then one of the spare codes stands in for it.
  task automatic send_tick(input logic sda);
    logic [2:0] op;
    case ($urandom_range(9))
      0:       op = OP_SPARE6;
      1:       op = OP_SPARE7;
      default: op = OP_TICK;
    endcase
    send_request(op, 8'($urandom), 1'($urandom_range(1)), sda);
  endtask

  // Ticks until the model goes idle. During the ack poll SDA stays high
  // until ack_after requests have gone by.
  task automatic tick_until_idle(input int ack_after, input int sda_mode);
    int   n;
    logic lvl;
    n = 0;
    while (bus_phase != PH_IDLE) begin
      if (bus_phase == PH_WA_HI || bus_phase == PH_WA_POLL)
        lvl = (n < ack_after);
      else if (sda_mode == SDA_RANDOM)
        lvl = 1'($urandom_range(1));
      else
        lvl = (sda_mode == SDA_HIGH);
      if (noise_pct != 0 && $urandom_range(99) < noise_pct)
        send_request(3'($urandom_range(int'(OP_START), int'(OP_READ))), 8'($urandom),
                     1'($urandom_range(1)), lvl);
      else
        send_tick(lvl);
      n++;
    end
  endtask

  task automatic run_command(input logic [2:0] op, input logic [7:0] data, input logic ack,
                             input int ack_after, input int sda_mode);
    send_request(op, data, ack, 1'($urandom_range(1)));
    tick_until_idle(ack_after, sda_mode);
  endtask

  // Holds requests back until every predicted result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_pins.size() != 0) @(posedge clk);
  endtask

  // Writes all three timing registers while the block is idle.
  task automatic load_timing(input logic [7:0] s, input logic [7:0] l, input logic [15:0] t);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SHORT_TICKS;
    cfg_data <= {8'h00, s};
    @(posedge clk);
    cfg_index <= CFG_LONG_TICKS;
    cfg_data <= {8'h00, l};
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_data <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    short_ticks_q = s;
    long_ticks_q = l;
    ack_timeout_q = t;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: ticks while idle change nothing, then a start and a stop
  // with the default timing.
  task automatic test_reset_defaults();
    send_request(OP_TICK, 8'h00, 1'b0, 1'b0);
    send_request(OP_SPARE6, 8'hFF, 1'b1, 1'b1);
    send_request(OP_SPARE7, 8'h5A, 1'b0, 1'b0);
    run_command(OP_START, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_STOP, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
  endtask

  // Every operation, byte extremes, busy rejection, ack and ack timeout.
  task automatic test_directed_ops();
    load_timing(8'd1, 8'd1, 16'd3);
    send_request(OP_START, 8'h00, 1'b0, 1'b1);
    send_request(OP_WRITE, 8'hFF, 1'b1, 1'b0);
    tick_until_idle(NEVER_ACK, SDA_RANDOM);
    run_command(OP_WRITE, 8'hFF, 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_WAITACK, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_command(OP_WRITE, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_WAITACK, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_START, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_READ, 8'h00, 1'b1, NEVER_ACK, SDA_HIGH);
    run_command(OP_READ, 8'h00, 1'b0, NEVER_ACK, SDA_LOW);
    run_command(OP_STOP, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
  endtask

  // Zero registers: every wait lasts one tick and the first high sample aborts.
  task automatic test_zero_registers();
    load_timing(8'd0, 8'd0, 16'd0);
    run_command(OP_START, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_WRITE, 8'($urandom), 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_WAITACK, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_START, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_READ, 8'h00, 1'b1, NEVER_ACK, SDA_RANDOM);
    run_command(OP_STOP, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
  endtask

  // Largest ack timeout: the full sixteen bits load, and an ack after a few
  // high samples ends the poll.
  task automatic test_max_registers();
    load_timing(8'd1, 8'd1, 16'hFFFF);
    run_command(OP_START, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_WRITE, 8'hA5, 1'b0, NEVER_ACK, SDA_RANDOM);
    run_command(OP_WAITACK, 8'h00, 1'b0, 6, SDA_RANDOM);
    run_command(OP_STOP, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
  endtask

  function automatic int pick_ack_delay();
    return ($urandom_range(99) < 15) ? NEVER_ACK : $urandom_range(0, 10);
  endfunction

  // Mostly complete bus transactions; some lone commands out of order.
  task automatic random_transaction();
    if ($urandom_range(99) < 20) begin
      run_command(3'($urandom_range(int'(OP_START), int'(OP_READ))), 8'($urandom),
                  1'($urandom_range(1)), pick_ack_delay(), SDA_RANDOM);
    end else begin
      run_command(OP_START, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
      run_command(OP_WRITE, 8'($urandom), 1'b0, NEVER_ACK, SDA_RANDOM);
      run_command(OP_WAITACK, 8'h00, 1'b0, pick_ack_delay(), SDA_RANDOM);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(1)) begin
          run_command(OP_WRITE, 8'($urandom), 1'b0, NEVER_ACK, SDA_RANDOM);
          run_command(OP_WAITACK, 8'h00, 1'b0, pick_ack_delay(), SDA_RANDOM);
        end else begin
          run_command(OP_READ, 8'h00, 1'($urandom_range(1)), NEVER_ACK, SDA_RANDOM);
        end
      end
      run_command(OP_STOP, 8'h00, 1'b0, NEVER_ACK, SDA_RANDOM);
    end
  endtask

  // Random traffic under each idle/stall pattern; the first two patterns
  // use random timing, the other two the fastest timing.
  task automatic test_random_traffic();
    int gaps[4]   = '{0, 48, 0, 20};
    int stalls[4] = '{0, 0, 48, 20};
    int budget;
    noise_pct = 3;
    for (int m = 0; m < 4; m++) begin
      gap_pct = gaps[m];
      stall_pct = stalls[m];
      if (m < 2)
        load_timing(8'($urandom_range(0, 1)), 8'($urandom_range(0, 4)),
                    16'($urandom_range(1, 12)));
      else
        load_timing(8'd1, 8'd1, 16'($urandom_range(1, 6)));
      budget = requests_sent + 90;
      while (requests_sent < budget) begin
        random_transaction();
        if ($urandom_range(9) == 0) drain_results();
      end
    end
    noise_pct = 0;
    gap_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SHORT_TICKS;
    cfg_data <= '0;
    reset_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_ops();
    test_zero_registers();
    test_max_registers();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && predicted_pins.size() == 0) begin
      $display("i2c_bit_level_master_top verification clean");
    end else begin
      $display("i2c_bit_level_master_top verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/i2cbm_pkg.sv
hw/rtl/i2cbm_core.sv
hw/rtl/i2cbm_out_buf.sv
hw/rtl/i2c_bit_level_master_top.sv
hw/rtl/i2cbm_checker.sv
tb/sv/tb_i2c_bit_level_master_top.sv
